// ===== src/wgbl_pkg.sv =====
// shared types and constants of the wrapped Gaussian bearing likelihood block
`default_nettype none

package wgbl_pkg;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_CENTER     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEGREES_PER_PIXEL = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAMERA_HEADING    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPREAD_VARIANCE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PEAK_SCALE        = 3'd4;

    // field widths
    localparam int BIN_W   = 9;
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 15;
    localparam int VAR_W   = 16;
    localparam int QUOT_W  = 20;
    localparam int LIK_W   = 16;
    localparam int M_DATA_W = LIK_W + ANGLE_W;

    // full turn in Q9.7 degrees
    localparam logic [ANGLE_W-1:0] TURN_Q7 = 16'd46080;

    // bearing stage result
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  arc;
        logic [ANGLE_W-1:0] bearing;
    } wgbl_geo_t;

    // divider result
    typedef struct packed {
        logic               valid;
        logic               zero;
        logic [QUOT_W-1:0]  quot;
        logic [ANGLE_W-1:0] bearing;
    } wgbl_ratio_t;

endpackage

`default_nettype wire

// ===== src/wgbl_bearing.sv =====
// bearing of the face center and circular distance to the requested bin
`default_nettype none

module wgbl_bearing #(
    parameter int PIXEL_BITS = 12
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire  [PIXEL_BITS-1:0]        face_left,
    input  wire  [PIXEL_BITS-1:0]        face_width,
    input  wire  [wgbl_pkg::BIN_W-1:0]   bin_angle,
    input  wire  [PIXEL_BITS-1:0]        camera_center,
    input  wire  [15:0]                  degrees_per_pixel,
    input  wire  [8:0]                   camera_heading,
    output wgbl_pkg::wgbl_geo_t          geo_out
);

    localparam int DW = PIXEL_BITS + 2;      // signed pixel offset
    localparam int UW = PIXEL_BITS + 19;     // offset angle, Q.12
    localparam int VW = UW - 15;             // angle in units of 2^15
    localparam int QW = PIXEL_BITS - 1;      // whole turns
    localparam int RK = PIXEL_BITS + 10;     // reciprocal shift
    localparam int RW = PIXEL_BITS + 5;      // reciprocal width
    localparam longint unsigned TURN_Q12 = 64'd1474560;
    localparam longint unsigned OFS_TURNS = ((64'd1 << (PIXEL_BITS + 16)) / TURN_Q12) + 64'd1;
    localparam longint unsigned OFS = OFS_TURNS * TURN_Q12 + TURN_Q12;
    localparam longint unsigned RECIP = ((64'd1 << RK) + 64'd44) / 64'd45;
    localparam logic [UW:0] OFS_EXT = (UW+1)'(OFS);
    localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

    // stage 1: box center minus image center
    logic                        v1_reg;
    logic signed [DW-1:0]        delta_reg, delta_next;
    logic [wgbl_pkg::BIN_W-1:0]  bin1_reg;
    logic [PIXEL_BITS:0]         center;

    always_comb begin
        center = {1'b0, face_left} + {2'b0, face_width[PIXEL_BITS-1:1]};
        delta_next = $signed({1'b0, center}) - $signed({2'b0, camera_center});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            delta_reg <= delta_next;
            bin1_reg  <= bin_angle;
        end
    end

    // stage 2: scale to degrees, add heading and a positive turn offset
    logic                        v2_reg;
    logic [UW-1:0]               u_reg, u_next;
    logic [wgbl_pkg::BIN_W-1:0]  bin2_reg;
    logic signed [UW-1:0]        prod;
    logic signed [UW:0]          prod_ext, acc;
    logic [UW:0]                 hd_ext;

    always_comb begin
        prod     = delta_reg * $signed({1'b0, degrees_per_pixel});
        prod_ext = (UW+1)'(prod);
        hd_ext   = (UW+1)'({camera_heading, 12'b0});
        acc      = prod_ext + $signed(OFS_EXT) + $signed(hd_ext);
        u_next   = acc[UW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            u_reg    <= u_next;
            bin2_reg <= bin1_reg;
        end
    end

    // stage 3: whole turns by reciprocal of 45 (one turn is 45 * 2^15)
    logic                        v3_reg;
    logic [QW-1:0]               q_reg, q_next;
    logic [VW-1:0]               vh_reg;
    logic [14:0]                 low_reg;
    logic [wgbl_pkg::BIN_W-1:0]  bin3_reg;
    logic [VW+RW-1:0]            qprod;

    always_comb begin
        qprod  = {{RW{1'b0}}, u_reg[UW-1:15]} * {{VW{1'b0}}, RECIP_C};
        q_next = qprod[RK +: QW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            q_reg    <= q_next;
            vh_reg   <= u_reg[UW-1:15];
            low_reg  <= u_reg[14:0];
            bin3_reg <= bin2_reg;
        end
    end

    // stage 4: remainder of the turn, truncated to Q9.7 (45q = 32q + 8q + 4q + q)
    logic                          v4_reg;
    logic [wgbl_pkg::ANGLE_W-1:0]  bearing4_reg, bearing4_next;
    logic [wgbl_pkg::BIN_W-1:0]    bin4_reg;
    logic [VW-1:0]                 rem_full;
    logic [20:0]                   angle;

    always_comb begin
        rem_full      = vh_reg - VW'({1'b0, q_reg, 5'b0} + {3'b0, q_reg, 3'b0}
                                     + {4'b0, q_reg, 2'b0} + {6'b0, q_reg});
        angle         = {rem_full[5:0], low_reg};
        bearing4_next = angle[20:5];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            bearing4_reg <= bearing4_next;
            bin4_reg     <= bin3_reg;
        end
    end

    // stage 5: shortest circular distance to the bin
    wgbl_pkg::wgbl_geo_t           geo_reg, geo_next;
    logic signed [17:0]            diff_raw;
    logic [wgbl_pkg::ANGLE_W-1:0]  diff, alt;

    always_comb begin
        diff_raw = $signed({2'b0, bin4_reg, 7'b0}) - $signed({2'b0, bearing4_reg});
        if (diff_raw < 0) begin
            diff = 16'(diff_raw + $signed({2'b0, wgbl_pkg::TURN_Q7}));
        end else if (diff_raw >= $signed({2'b0, wgbl_pkg::TURN_Q7})) begin
            diff = 16'(diff_raw - $signed({2'b0, wgbl_pkg::TURN_Q7}));
        end else begin
            diff = diff_raw[15:0];
        end
        alt = wgbl_pkg::TURN_Q7 - diff;
        geo_next.valid   = v4_reg;
        geo_next.arc     = (diff < alt) ? diff[14:0] : alt[14:0];
        geo_next.bearing = bearing4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geo_reg.valid <= 1'b0;
        end else if (en) begin
            geo_reg.valid <= geo_next.valid;
        end
        if (en) begin
            geo_reg.arc     <= geo_next.arc;
            geo_reg.bearing <= geo_next.bearing;
        end
    end

    assign geo_out = geo_reg;

endmodule

`default_nettype wire

// ===== src/wgbl_divider.sv =====
// squared distance and pipelined restoring division by the variance
`default_nettype none

module wgbl_divider (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wgbl_pkg::wgbl_geo_t          geo_in,
    input  wire  [wgbl_pkg::VAR_W-1:0]   var_eff,
    output wgbl_pkg::wgbl_ratio_t        ratio_out
);

    localparam int QW = wgbl_pkg::QUOT_W;
    localparam int NW = 30;
    localparam int CW = wgbl_pkg::VAR_W + QW;

    logic                          valid_reg [0:QW];
    logic                          zero_reg  [0:QW];
    logic [NW-1:0]                 rem_reg   [0:QW];
    logic [QW-1:0]                 quot_reg  [0:QW];
    logic [wgbl_pkg::ANGLE_W-1:0]  bear_reg  [0:QW];

    // stage 0: numerator 2*d^2 and the exponent range check
    logic [NW-1:0] sq;
    logic [NW-1:0] num_next;
    logic          zero_next;

    always_comb begin
        sq        = {{(NW-wgbl_pkg::DIST_W){1'b0}}, geo_in.arc}
                  * {{(NW-wgbl_pkg::DIST_W){1'b0}}, geo_in.arc};
        num_next  = {sq[NW-2:0], 1'b0};
        zero_next = {{(CW-NW){1'b0}}, num_next} >= {var_eff, {QW{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= geo_in.valid;
        end
        if (en) begin
            zero_reg[0] <= zero_next;
            rem_reg[0]  <= num_next;
            quot_reg[0] <= '0;
            bear_reg[0] <= geo_in.bearing;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int J = QW - k;
        logic [CW-1:0] dvs;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quot_next;

        always_comb begin
            dvs       = {{QW{1'b0}}, var_eff} << J;
            ge        = {{(CW-NW){1'b0}}, rem_reg[k-1]} >= dvs;
            rem_next  = ge ? NW'({{(CW-NW){1'b0}}, rem_reg[k-1]} - dvs) : rem_reg[k-1];
            quot_next = {quot_reg[k-1][QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
            if (en) begin
                zero_reg[k] <= zero_reg[k-1];
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                bear_reg[k] <= bear_reg[k-1];
            end
        end
    end

    always_comb begin
        ratio_out.valid   = valid_reg[QW];
        ratio_out.zero    = zero_reg[QW];
        ratio_out.quot    = quot_reg[QW];
        ratio_out.bearing = bear_reg[QW];
    end

endmodule

`default_nettype wire

// ===== src/wgbl_exp.sv =====
// exp table lookup with linear interpolation and peak scaling
`default_nettype none

module wgbl_exp #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           en,
    input  wgbl_pkg::wgbl_ratio_t         ratio_in,
    input  wire  [15:0]                   peak_scale,
    output logic                          out_valid,
    output logic [wgbl_pkg::LIK_W-1:0]    likelihood,
    output logic [wgbl_pkg::ANGLE_W-1:0]  bearing
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH);
    localparam int AW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int QW = wgbl_pkg::QUOT_W;
    localparam int PW = QW + AW;
    localparam longint unsigned STEP_Q32 = (64'd1 << 36) / EXP_TABLE_DEPTH;

    typedef logic [32:0] exp_tab_t [0:EXP_TABLE_DEPTH];

    // exp(-16k/depth) in Q.32, built by powers of one Taylor-series step
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t          tab;
        longint unsigned   t;
        longint unsigned   tm;
        longint unsigned   ev;
        longint unsigned   od;
        longint unsigned   c;
        longint unsigned   cur;
        t  = STEP_Q32;
        tm = 64'd1 << 32;
        ev = 64'd1 << 32;
        od = 64'd0;
        tm = ((tm * t) >> 32) / 64'd1;  od += tm;
        tm = ((tm * t) >> 32) / 64'd2;  ev += tm;
        tm = ((tm * t) >> 32) / 64'd3;  od += tm;
        tm = ((tm * t) >> 32) / 64'd4;  ev += tm;
        tm = ((tm * t) >> 32) / 64'd5;  od += tm;
        tm = ((tm * t) >> 32) / 64'd6;  ev += tm;
        tm = ((tm * t) >> 32) / 64'd7;  od += tm;
        tm = ((tm * t) >> 32) / 64'd8;  ev += tm;
        tm = ((tm * t) >> 32) / 64'd9;  od += tm;
        tm = ((tm * t) >> 32) / 64'd10; ev += tm;
        tm = ((tm * t) >> 32) / 64'd11; od += tm;
        tm = ((tm * t) >> 32) / 64'd12; ev += tm;
        tm = ((tm * t) >> 32) / 64'd13; od += tm;
        tm = ((tm * t) >> 32) / 64'd14; ev += tm;
        tm = ((tm * t) >> 32) / 64'd15; od += tm;
        tm = ((tm * t) >> 32) / 64'd16; ev += tm;
        tm = ((tm * t) >> 32) / 64'd17; od += tm;
        tm = ((tm * t) >> 32) / 64'd18; ev += tm;
        tm = ((tm * t) >> 32) / 64'd19; od += tm;
        tm = ((tm * t) >> 32) / 64'd20; ev += tm;
        tm = ((tm * t) >> 32) / 64'd21; od += tm;
        tm = ((tm * t) >> 32) / 64'd22; ev += tm;
        tm = ((tm * t) >> 32) / 64'd23; od += tm;
        tm = ((tm * t) >> 32) / 64'd24; ev += tm;
        c   = ev - od;
        cur = 64'd1 << 32;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            tab[k] = cur[32:0];
            cur    = (cur * c) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();
    localparam logic [AW-1:0] DEPTH_C = AW'(EXP_TABLE_DEPTH);

    // stage 1: table position and fraction
    logic                          v1_reg, z1_reg;
    logic [IW-1:0]                 idx_reg;
    logic [19:0]                   frac1_reg;
    logic [wgbl_pkg::ANGLE_W-1:0]  b1_reg;
    logic [PW-1:0]                 pos;

    always_comb begin
        pos = {{AW{1'b0}}, ratio_in.quot} * {{QW{1'b0}}, DEPTH_C};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ratio_in.valid;
        end
        if (en) begin
            z1_reg    <= ratio_in.zero;
            idx_reg   <= pos[20 +: IW];
            frac1_reg <= pos[19:0];
            b1_reg    <= ratio_in.bearing;
        end
    end

    // stage 2: read both neighbor entries
    logic                          v2_reg, z2_reg;
    logic [32:0]                   t0_reg, t1_reg;
    logic [19:0]                   frac2_reg;
    logic [wgbl_pkg::ANGLE_W-1:0]  b2_reg;
    logic [AW-1:0]                 ia, ib;

    always_comb begin
        ia = AW'(idx_reg);
        ib = ia + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            z2_reg    <= z1_reg;
            t0_reg    <= EXP_TAB[ia];
            t1_reg    <= EXP_TAB[ib];
            frac2_reg <= frac1_reg;
            b2_reg    <= b1_reg;
        end
    end

    // stage 3: slope times fraction
    logic                          v3_reg, z3_reg;
    logic [32:0]                   t03_reg;
    logic [31:0]                   corr_reg;
    logic [wgbl_pkg::ANGLE_W-1:0]  b3_reg;
    logic [32:0]                   slope;
    logic [51:0]                   sprod;

    always_comb begin
        slope = t0_reg - t1_reg;
        sprod = {20'b0, slope[31:0]} * {32'b0, frac2_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            z3_reg   <= z2_reg;
            t03_reg  <= t0_reg;
            corr_reg <= sprod[51:20];
            b3_reg   <= b2_reg;
        end
    end

    // stage 4: interpolated exp
    logic                          v4_reg, z4_reg;
    logic [32:0]                   e_reg, e_next;
    logic [wgbl_pkg::ANGLE_W-1:0]  b4_reg;

    always_comb begin
        e_next = t03_reg - {1'b0, corr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
        if (en) begin
            z4_reg <= z3_reg;
            e_reg  <= e_next;
            b4_reg <= b3_reg;
        end
    end

    // stage 5: peak scaling with rounding, zero for out-of-range ratios, output register
    logic                          vo_reg;
    logic [wgbl_pkg::LIK_W-1:0]    lik_reg, lik_next;
    logic [wgbl_pkg::ANGLE_W-1:0]  bo_reg;
    logic [48:0]                   lprod;

    always_comb begin
        lprod    = {16'b0, e_reg} * {33'b0, peak_scale} + (49'd1 << 31);
        lik_next = z4_reg ? '0 : lprod[47:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v4_reg;
        end
        if (en) begin
            lik_reg <= lik_next;
            bo_reg  <= b4_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign likelihood = lik_reg;
    assign bearing    = bo_reg;

endmodule

`default_nettype wire

// ===== src/wrapped_gaussian_bearing_likelihood.sv =====
// Wrapped Gaussian bearing likelihood: takes one face box and bearing bin per
// transfer and returns the Q0.16 likelihood and Q9.7 bearing. Fully pipelined:
// a new item is taken every cycle while the output is not stalled (31 register
// stages: 5 bearing stages, a squaring stage and 20 divider stages of one
// quotient bit each, 5 exp-table stages). A stall on the result side holds
// the whole pipeline; input ready follows the output register.
`default_nettype none

module wrapped_gaussian_bearing_likelihood #(
    parameter int PIXEL_BITS      = 12,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // tdata: face_left, face_width, bin_angle, zero pad
    input  wire  [((2*PIXEL_BITS+9+7)/8)*8-1:0]  s_tdata,
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // tdata: likelihood, bearing
    output logic [wgbl_pkg::M_DATA_W-1:0]        m_tdata,
    // configuration writes
    input  wire                                  cfg_we,
    input  wire  [wgbl_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [wgbl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int PB = PIXEL_BITS;

    // configuration registers
    logic [PB-1:0]  camera_center_reg;
    logic [15:0]    degrees_per_pixel_reg;
    logic [8:0]     camera_heading_reg;
    logic [15:0]    spread_variance_reg;
    logic [15:0]    peak_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_center_reg     <= PB'(320);
            degrees_per_pixel_reg <= 16'd384;
            camera_heading_reg    <= 9'd0;
            spread_variance_reg   <= 16'd100;
            peak_scale_reg        <= 16'd2615;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                wgbl_pkg::CFG_CAMERA_CENTER:     camera_center_reg <= cfg_wdata[PB-1:0];
                wgbl_pkg::CFG_DEGREES_PER_PIXEL: degrees_per_pixel_reg <= cfg_wdata;
                wgbl_pkg::CFG_CAMERA_HEADING:    camera_heading_reg <= cfg_wdata[8:0];
                wgbl_pkg::CFG_SPREAD_VARIANCE:   spread_variance_reg <= cfg_wdata;
                wgbl_pkg::CFG_PEAK_SCALE:        peak_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // zero variance acts as one
    logic [15:0] var_eff;
    assign var_eff = (spread_variance_reg == 16'd0) ? 16'd1 : spread_variance_reg;

    // pipeline advance whenever the output register is free or drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    wgbl_pkg::wgbl_geo_t    geo;
    wgbl_pkg::wgbl_ratio_t  ratio;
    logic [wgbl_pkg::LIK_W-1:0]   likelihood;
    logic [wgbl_pkg::ANGLE_W-1:0] bearing;

    wgbl_bearing #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_bearing (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (s_tvalid),
        .face_left         (s_tdata[PB-1:0]),
        .face_width        (s_tdata[2*PB-1:PB]),
        .bin_angle         (s_tdata[2*PB+8:2*PB]),
        .camera_center     (camera_center_reg),
        .degrees_per_pixel (degrees_per_pixel_reg),
        .camera_heading    (camera_heading_reg),
        .geo_out           (geo)
    );

    wgbl_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .geo_in    (geo),
        .var_eff   (var_eff),
        .ratio_out (ratio)
    );

    wgbl_exp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ratio_in   (ratio),
        .peak_scale (peak_scale_reg),
        .out_valid  (m_tvalid),
        .likelihood (likelihood),
        .bearing    (bearing)
    );

    assign m_tdata = {bearing, likelihood};

endmodule

`default_nettype wire

// ===== src/wgbl_checker.sv =====
// port-level checks of the bearing likelihood block and their binding
`default_nettype none

module wgbl_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tready,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a stalled output stalls the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // bearing stays inside one turn
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:16] < 16'd46080)
        else $error("bearing out of range");

endmodule

bind wrapped_gaussian_bearing_likelihood wgbl_checker u_wgbl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
